### sv/bsfp_pkg.sv
`default_nettype none

package bsfp_pkg;

  // Default limit on AD records reported per frame.
  localparam int unsigned MAX_AD_RECORDS_DEFAULT = 16;

  // Depth of the record queue between parser and output; a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Record kinds.
  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_AD        = 3'd1;
  localparam logic [2:0] KIND_SCAN_REQ  = 3'd2;
  localparam logic [2:0] KIND_TRAILER   = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED = 3'd4;

  // PDU types of interest.
  localparam logic [3:0] PDU_ADV_IND  = 4'h0;
  localparam logic [3:0] PDU_SCAN_REQ = 4'h3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [5:0] radio_channel;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [5:0]  channel_out;
    logic [42:0] time_stamp;
    logic [31:0] access_addr;
    logic [15:0] pdu_header_word;
    logic [47:0] first_address;
    logic [47:0] second_address;
    logic [7:0]  ad_kind;
    logic [7:0]  ad_data_length;
    logic [7:0]  ad_data_offset;
    logic [23:0] frame_crc;
    logic        last_of_run;
  } out_item_t;

  // Records caused by one byte: a parsed record first, then the trailer.
  typedef struct packed {
    logic      first_valid;
    logic      trailer_valid;
    out_item_t first_rec;
    out_item_t trailer_rec;
  } rec_pair_t;

endpackage

`default_nettype wire

### sv/ble_sniffer_frame_parser.sv
// A record caused by a byte is written into the output queue as the byte is taken; a
// second record from the same byte is written in the same cycle, behind it.
// Throughput: one byte per cycle in unless full, one record per cycle out unless empty;
// full rises while the four-entry record queue has room for fewer than two records.
// Reset: all parser state returns to its frame-start values and the queue is emptied.
`default_nettype none

module ble_sniffer_frame_parser #(
  parameter int unsigned MaxAdRecords = bsfp_pkg::MAX_AD_RECORDS_DEFAULT
) (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic push,
  output logic                      full,
  input  wire   bsfp_pkg::in_item_t in_item_i,
  output logic                      empty,
  input  wire                 logic pop,
  output bsfp_pkg::out_item_t       out_item_o
);
  import bsfp_pkg::*;

  // The front end walks the frame one byte per accepted item. It keeps the
  // running byte position, the timestamp, access address and header
  // accumulators, the shift registers for the two payload addresses and the
  // small walk over AD structures. From these it forms at most two records
  // per byte: a parsed record (header, scan request or AD structure) and,
  // on the final byte, the trailer or truncated record.
  //
  // The back end is a short queue of records. It writes both records of a
  // byte in the same cycle and hands them out oldest first, so the parser keeps
  // taking bytes while the consumer stalls, until the queue cannot hold the
  // worst case of another byte.

  logic      accept;
  rec_pair_t recs;

  assign accept = push & ~full;

  bsfp_front #(
    .MaxAdRecords (MaxAdRecords)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .recs_o    (recs)
  );

  bsfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .recs_i  (recs),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (out_item_o)
  );

endmodule

`default_nettype wire

### sv/bsfp_front.sv
`default_nettype none

module bsfp_front #(
  parameter int unsigned MaxAdRecords = bsfp_pkg::MAX_AD_RECORDS_DEFAULT
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic accept_i,
  input  wire  bsfp_pkg::in_item_t in_item_i,
  output bsfp_pkg::rec_pair_t      recs_o
);
  import bsfp_pkg::*;

  typedef enum logic {
    PhaseIdle,
    PhaseType
  } ad_phase_e;

  ad_phase_e   phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [5:0]  chan_q, chan_d;
  logic [47:0] time_q, time_d;
  logic [31:0] access_q, access_d;
  logic [15:0] header_q, header_d;
  logic [47:0] addr1_q, addr1_d;
  logic [47:0] addr2_q, addr2_d;
  logic [7:0]  next_ad_q, next_ad_d;
  logic [7:0]  pend_len_q, pend_len_d;
  logic [4:0]  ad_count_q, ad_count_d;
  logic [23:0] tail_q, tail_d;

  logic [7:0]  b;
  logic [7:0]  off;
  logic [7:0]  ad_len;
  logic [8:0]  ad_next;
  logic        last;
  logic        prim_valid;
  logic [2:0]  prim_kind;
  logic [7:0]  prim_ad_kind;
  logic        prim_use_addr1;
  logic        prim_use_addr2;
  out_item_t   base;

  always_comb begin
    b          = in_item_i.frame_byte;
    last       = in_item_i.frame_end;
    off        = pos_q - 8'd16;
    ad_len     = pend_len_q - 8'd1;
    ad_next    = {1'b0, off} + 9'd1 + {1'b0, ad_len};

    phase_d    = phase_q;
    chan_d     = (pos_q == 8'd0) ? in_item_i.radio_channel : chan_q;
    time_d     = time_q;
    access_d   = access_q;
    header_d   = header_q;
    addr1_d    = addr1_q;
    addr2_d    = addr2_q;
    next_ad_d  = next_ad_q;
    pend_len_d = pend_len_q;
    ad_count_d = ad_count_q;
    tail_d     = {b, tail_q[23:8]};

    prim_valid     = 1'b0;
    prim_kind      = KIND_HEADER;
    prim_ad_kind   = 8'd0;
    prim_use_addr1 = 1'b0;
    prim_use_addr2 = 1'b0;

    for (int k = 0; k < 6; k++) begin
      if (pos_q == 8'(k + 3)) begin
        time_d[8*k +: 8] = time_q[8*k +: 8] | b;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (pos_q == 8'(k + 10)) begin
        access_d[8*k +: 8] = access_q[8*k +: 8] | b;
      end
    end

    if (pos_q == 8'd14) begin
      header_d[7:0] = b;
    end else if (pos_q == 8'd15) begin
      header_d[15:8] = b;
      prim_valid     = 1'b1;
      prim_kind      = KIND_HEADER;
    end else if (pos_q >= 8'd16) begin
      if (off <= 8'd5) begin
        addr1_d = {addr1_q[39:0], b};
      end else if (off <= 8'd11) begin
        addr2_d = {addr2_q[39:0], b};
      end

      if (header_q[3:0] == PDU_SCAN_REQ && off == 8'd11) begin
        prim_valid     = 1'b1;
        prim_kind      = KIND_SCAN_REQ;
        prim_use_addr1 = 1'b1;
        prim_use_addr2 = 1'b1;
      end

      if (header_q[3:0] == PDU_ADV_IND) begin
        if (phase_q == PhaseType) begin
          if (ad_count_q < 5'(MaxAdRecords)) begin
            prim_valid     = 1'b1;
            prim_kind      = KIND_AD;
            prim_ad_kind   = b;
            prim_use_addr1 = 1'b1;
          end
          if (ad_count_q != 5'd31) begin
            ad_count_d = ad_count_q + 5'd1;
          end
          next_ad_d = ad_next[8] ? 8'hFF : ad_next[7:0];
          phase_d   = PhaseIdle;
        end else if (off == next_ad_q && next_ad_q < {2'b00, header_q[13:8]}) begin
          pend_len_d = b;
          phase_d    = PhaseType;
        end
      end
    end

    // Context fields as they stand after this byte.
    base                 = '0;
    base.channel_out     = chan_d;
    base.time_stamp      = time_d[47:5];
    base.access_addr     = access_d;
    base.pdu_header_word = header_d;

    recs_o.first_valid                  = accept_i & prim_valid;
    recs_o.first_rec                    = base;
    recs_o.first_rec.record_kind        = prim_kind;
    recs_o.first_rec.first_address      = prim_use_addr1 ? addr1_d : 48'd0;
    recs_o.first_rec.second_address     = prim_use_addr2 ? addr2_d : 48'd0;
    recs_o.first_rec.ad_kind            = prim_ad_kind;
    recs_o.first_rec.ad_data_length     = (prim_kind == KIND_AD) ? ad_len : 8'd0;
    recs_o.first_rec.ad_data_offset     = (prim_kind == KIND_AD) ? off + 8'd1 : 8'd0;
    recs_o.first_rec.last_of_run        = ~last;

    recs_o.trailer_valid                = accept_i & last;
    recs_o.trailer_rec                  = base;
    recs_o.trailer_rec.record_kind      = (pos_q < 8'd15) ? KIND_TRUNCATED : KIND_TRAILER;
    recs_o.trailer_rec.frame_crc        = tail_d;
    recs_o.trailer_rec.last_of_run      = 1'b1;

    // The end of a frame puts the per-frame state back to its reset values.
    if (last) begin
      pos_d      = 8'd0;
      phase_d    = PhaseIdle;
      time_d     = '0;
      access_d   = '0;
      header_d   = '0;
      addr1_d    = '0;
      addr2_d    = '0;
      next_ad_d  = 8'd6;
      pend_len_d = '0;
      ad_count_d = '0;
      tail_d     = '0;
    end else begin
      pos_d = (pos_q != 8'hFF) ? pos_q + 8'd1 : pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhaseIdle;
      pos_q      <= 8'd0;
      chan_q     <= '0;
      time_q     <= '0;
      access_q   <= '0;
      header_q   <= '0;
      addr1_q    <= '0;
      addr2_q    <= '0;
      next_ad_q  <= 8'd6;
      pend_len_q <= '0;
      ad_count_q <= '0;
      tail_q     <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      chan_q     <= chan_d;
      time_q     <= time_d;
      access_q   <= access_d;
      header_q   <= header_d;
      addr1_q    <= addr1_d;
      addr2_q    <= addr2_d;
      next_ad_q  <= next_ad_d;
      pend_len_q <= pend_len_d;
      ad_count_q <= ad_count_d;
      tail_q     <= tail_d;
    end
  end

endmodule

`default_nettype wire

### sv/bsfp_queue.sv
`default_nettype none

module bsfp_queue (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire  bsfp_pkg::rec_pair_t recs_i,
  output logic                      full_o,
  output logic                      empty_o,
  input  wire                 logic pop_i,
  output bsfp_pkg::out_item_t       head_o
);
  import bsfp_pkg::*;

  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  out_item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [PtrW-1:0]     trailer_ptr;
  logic [1:0]          n_wr;
  logic                do_pop;

  assign empty_o = (count_q == '0);
  // Room is kept for the two records one byte may cause.
  assign full_o  = (count_q > CountW'(QUEUE_DEPTH - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    n_wr        = {1'b0, recs_i.first_valid} + {1'b0, recs_i.trailer_valid};
    trailer_ptr = recs_i.first_valid ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    wr_ptr_d    = wr_ptr_q + PtrW'(n_wr);
    rd_ptr_d    = rd_ptr_q + PtrW'(do_pop);
    count_d     = count_q + CountW'(n_wr) - CountW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (recs_i.first_valid) begin
      mem_q[wr_ptr_q] <= recs_i.first_rec;
    end
    if (recs_i.trailer_valid) begin
      mem_q[trailer_ptr] <= recs_i.trailer_rec;
    end
  end

endmodule

`default_nettype wire
